// File: hdl/nms_pkg.sv
package nms_pkg;
  localparam int MaxItems = 64;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef logic signed [31:0] data_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  keep;
  } cmd_t;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  ovf;
  } res_t;
endpackage

// File: hdl/nms_front.sv
module nms_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [31:0]   in_value,
  input  logic          in_last_item,
  output nms_pkg::cmd_t q_data,
  output logic          q_valid,
  input  logic          q_take
);
  nms_pkg::cmd_t mem_r [nms_pkg::QDepth];
  logic [nms_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [nms_pkg::QPtrW:0] cnt_r;
  nms_pkg::cnt_t seen_r;
  logic wr, rd;

  assign in_full = (cnt_r == (nms_pkg::QPtrW+1)'(nms_pkg::QDepth));
  assign wr = in_push && !in_full;
  assign q_valid = (cnt_r != '0);
  assign rd = q_take && q_valid;
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r].value <= in_value;
      mem_r[wp_r].last <= in_last_item;
      mem_r[wp_r].keep <= (seen_r < nms_pkg::cnt_t'(nms_pkg::MaxItems));
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
      seen_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= wp_r + 1'b1;
        if (in_last_item) seen_r <= '0;
        else if (seen_r < nms_pkg::cnt_t'(nms_pkg::MaxItems)) seen_r <= seen_r + 1'b1;
      end
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (nms_pkg::QPtrW+1)'(wr) - (nms_pkg::QPtrW+1)'(rd);
    end
  end

`ifndef SYNTH
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !(cnt_r > (nms_pkg::QPtrW+1)'(nms_pkg::QDepth))) else $error("queue overrun");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_take && !wr) |=> q_valid) else $error("queue lost item");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !rd) |=> in_full) else $error("full dropped");
`endif
endmodule

// File: hdl/nms_back.sv
module nms_back (
  input  logic          clk,
  input  logic          rst_n,
  input  nms_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_take,
  output nms_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_take
);
  typedef enum logic [2:0] {LOAD, DIST, MRUN, MSET, MERGE, EMIT} st_t;
  st_t st_r;
  nms_pkg::data_t ms_r [nms_pkg::MaxItems];
  nms_pkg::data_t ta_r [nms_pkg::MaxItems];
  nms_pkg::data_t tb_r [nms_pkg::MaxItems];
  nms_pkg::idx_t rea_r [nms_pkg::MaxItems];
  nms_pkg::idx_t reb_r [nms_pkg::MaxItems];
  nms_pkg::data_t ms_q_r, ta_q_r, tb_q_r;
  nms_pkg::idx_t rea_q_r, reb_q_r;
  nms_pkg::cnt_t n_r, i_r, ca_r, cb_r, ra_r, rb_r, pa_r, pb_r, k_r, ea_r, eb_r;
  logic ovf_r, on_a_r, have_prev_r, rdv_r, e_rdy_r;
  nms_pkg::data_t prev_r;
  logic brk, ta_rem, tb_rem, take_a, m_go, e_go;
  nms_pkg::idx_t ms_ra, ta_ra, tb_ra;

  assign q_take = (st_r == LOAD);
  assign brk = have_prev_r && (ms_q_r < prev_r);
  assign ta_rem = pa_r < ea_r;
  assign tb_rem = pb_r < eb_r;
  assign take_a = ta_rem && (!tb_rem || ta_q_r <= tb_q_r);
  assign m_go = (st_r == MERGE) && (ta_rem || tb_rem);
  assign e_go = (st_r == EMIT) && e_rdy_r && (n_r != '0) && (!res_valid || res_take);
  // read ports run one address ahead while a stream advances
  assign ms_ra = i_r[nms_pkg::IdxW-1:0] + nms_pkg::idx_t'(e_go);
  assign ta_ra = pa_r[nms_pkg::IdxW-1:0] + nms_pkg::idx_t'(m_go && take_a);
  assign tb_ra = pb_r[nms_pkg::IdxW-1:0] + nms_pkg::idx_t'(m_go && !take_a);

  always_ff @(posedge clk) begin
    ms_q_r <= ms_r[ms_ra];
    ta_q_r <= ta_r[ta_ra];
    tb_q_r <= tb_r[tb_ra];
    rea_q_r <= rea_r[k_r[nms_pkg::IdxW-1:0]];
    reb_q_r <= reb_r[k_r[nms_pkg::IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LOAD;
      n_r <= '0;
      ovf_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      unique case (st_r)
        LOAD: if (q_valid) begin
          if (q_data.keep) begin
            ms_r[n_r[nms_pkg::IdxW-1:0]] <= q_data.value;
            n_r <= n_r + 1'b1;
          end else ovf_r <= 1'b1;
          if (q_data.last) begin
            st_r <= DIST;
            i_r <= '0; ca_r <= '0; cb_r <= '0; ra_r <= '0; rb_r <= '0;
            on_a_r <= 1'b1; rdv_r <= 1'b0; have_prev_r <= 1'b0;
          end
        end
        DIST: begin
          if (rdv_r) begin
            if (brk) begin
              if (on_a_r) begin
                rea_r[ra_r[nms_pkg::IdxW-1:0]] <= nms_pkg::idx_t'(ca_r - 1'b1);
                ra_r <= ra_r + 1'b1;
              end else begin
                reb_r[rb_r[nms_pkg::IdxW-1:0]] <= nms_pkg::idx_t'(cb_r - 1'b1);
                rb_r <= rb_r + 1'b1;
              end
              on_a_r <= !on_a_r;
            end
            if (on_a_r ^ brk) begin
              ta_r[ca_r[nms_pkg::IdxW-1:0]] <= ms_q_r;
              ca_r <= ca_r + 1'b1;
            end else begin
              tb_r[cb_r[nms_pkg::IdxW-1:0]] <= ms_q_r;
              cb_r <= cb_r + 1'b1;
            end
            prev_r <= ms_q_r;
            have_prev_r <= 1'b1;
          end
          if (i_r < n_r) begin
            i_r <= i_r + 1'b1;
            rdv_r <= 1'b1;
          end else rdv_r <= 1'b0;
          if (i_r == n_r && !rdv_r) begin
            // close the final run
            if (on_a_r) begin
              rea_r[ra_r[nms_pkg::IdxW-1:0]] <= nms_pkg::idx_t'(ca_r - 1'b1);
              ra_r <= ra_r + 1'b1;
            end else begin
              reb_r[rb_r[nms_pkg::IdxW-1:0]] <= nms_pkg::idx_t'(cb_r - 1'b1);
              rb_r <= rb_r + 1'b1;
            end
            i_r <= '0;
            if ((ra_r + rb_r) != '0) begin
              st_r <= MRUN;
              pa_r <= '0; pb_r <= '0; k_r <= '0;
            end else begin
              st_r <= EMIT;
              e_rdy_r <= 1'b0;
            end
          end
        end
        MRUN: begin
          if (k_r == ra_r) begin
            st_r <= DIST;
            i_r <= '0; ca_r <= '0; cb_r <= '0; ra_r <= '0; rb_r <= '0;
            on_a_r <= 1'b1; rdv_r <= 1'b0; have_prev_r <= 1'b0;
          end else st_r <= MSET;
        end
        MSET: begin
          ea_r <= nms_pkg::cnt_t'(rea_q_r) + 1'b1;
          eb_r <= (k_r < rb_r) ? nms_pkg::cnt_t'(reb_q_r) + 1'b1 : pb_r;
          st_r <= MERGE;
        end
        MERGE: begin
          if (!ta_rem && !tb_rem) begin
            k_r <= k_r + 1'b1;
            st_r <= MRUN;
          end else begin
            ms_r[i_r[nms_pkg::IdxW-1:0]] <= take_a ? ta_q_r : tb_q_r;
            i_r <= i_r + 1'b1;
            if (take_a) pa_r <= pa_r + 1'b1;
            else pb_r <= pb_r + 1'b1;
          end
        end
        EMIT: begin
          if (n_r == '0) begin
            st_r <= LOAD; ovf_r <= 1'b0;
          end else if (!e_rdy_r) e_rdy_r <= 1'b1;
          else if (e_go) begin
            res_valid <= 1'b1;
            res.value <= ms_q_r;
            res.last <= (i_r + 1'b1 == n_r);
            res.ovf <= ovf_r;
            i_r <= i_r + 1'b1;
            if (i_r + 1'b1 == n_r) begin
              st_r <= LOAD; n_r <= '0; ovf_r <= 1'b0;
            end
          end
        end
        default: st_r <= LOAD;
      endcase
      if (res_take && res_valid && !e_go) res_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= nms_pkg::cnt_t'(nms_pkg::MaxItems)) else $error("count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> res_valid && $stable(res)) else $error("hold");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != LOAD) |-> !q_take) else $error("take");
`endif
endmodule

// File: hdl/natural_merge_sorter_core.sv
// Load: one item per cycle through a 4-entry queue into the back end, while the queue is not full.
// Sort: each pass distributes the runs of the store alternately into two tables, then
//   merges run pairs back; 64 values need at most 6 passes plus a final distribute.
// Output: after a sorted load, results follow one per cycle while out_pop takes each one.
// A new load may queue while the back end sorts; it is taken once the last result is out.
// Sync active-low reset clears control; stores hold garbage until written.
module natural_merge_sorter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_value,
  input  logic        in_last_item,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [31:0] out_sorted_value,
  output logic        out_last_result,
  output logic        out_overflow
);
  nms_pkg::cmd_t qd;
  nms_pkg::res_t rs;
  logic qv, qt, rv;

  nms_front u_front (.clk, .rst_n, .in_push, .in_full, .in_value, .in_last_item,
    .q_data(qd), .q_valid(qv), .q_take(qt));
  nms_back u_back (.clk, .rst_n, .q_data(qd), .q_valid(qv), .q_take(qt),
    .res(rs), .res_valid(rv), .res_take(out_pop));

  assign out_empty = !rv;
  assign out_sorted_value = rs.value;
  assign out_last_result = rs.last;
  assign out_overflow = rs.ovf;
endmodule
